FILE: hw/rtl/ptte_pkg.sv
// types, constants and helper functions shared by the postfix truth table evaluator
// no dependencies; imported by ptte_cell, ptte_ctrl and the top level
`timescale 1ns / 1ps
`default_nettype none

package ptte_pkg;

	localparam int VEC_MAX_W = 64;  // widest truth vector, six variables
	localparam int MODE_W    = 4;
	localparam int VAR_W     = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_VAR     = 4'd0,
		MODE_ONE     = 4'd1,
		MODE_ZERO    = 4'd2,
		MODE_NOT     = 4'd3,
		MODE_OR      = 4'd4,
		MODE_AND     = 4'd5,
		MODE_EQUIV   = 4'd6,
		MODE_IMPLIES = 4'd7,
		MODE_XOR     = 4'd8,
		MODE_NOR     = 4'd9,
		MODE_NAND    = 4'd10
	} ptte_mode_t;

	typedef enum logic [1:0] {
		SHIFT_HOLD = 2'd0,
		SHIFT_UP   = 2'd1,
		SHIFT_DOWN = 2'd2
	} ptte_shift_t;

	// stack movement for one accepted beat
	typedef struct packed {
		logic push;
		logic pop;
		logic load_top;
	} ptte_stack_ctl_t;

	// row i is set when bit pos of i is one
	function automatic logic [VEC_MAX_W-1:0] ptte_column(input logic [VAR_W-1:0] pos);
		logic [VEC_MAX_W-1:0] c;
		logic [5:0]           row;
		logic [5:0]           sh;
		c = '0;
		for (int i = 0; i < VEC_MAX_W; i++) begin
			row  = 6'(i);
			sh   = row >> pos;
			c[i] = sh[0];
		end
		return c;
	endfunction

	function automatic logic [VEC_MAX_W-1:0] ptte_row_mask(input logic [VAR_W-1:0] v);
		logic [6:0] n;
		n = 7'd1 << v;
		if (v >= 3'd6) begin
			return '1;
		end
		return (64'd1 << n) - 64'd1;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/postfix_truth_table_evaluator_unit.sv
// top level of the postfix truth table evaluator: config register, cell row, control
// depends on ptte_pkg, ptte_cell and ptte_ctrl
`timescale 1ns / 1ps
`default_nettype none

// Takes one postfix token per cycle and keeps a stack of truth vectors (one bit per
// row of up to MAX_VARS variables) in a row of STACK_DEPTH cells, top entry in cell 0.
// A push shifts every cell down by one, a binary token writes its result into cell 0
// and shifts the rest up, NOT rewrites cell 0; all in the same cycle, so a token is
// taken every clock while the result register is free or being drained. A token
// marked last produces one result beat in the cycle after it is taken; other tokens
// produce none. var_count is written through the cfg channel (always ready) and must
// only change between formulas. Errors (underflow, overflow, bad index, unknown token,
// final depth not one) give error=1 with zero truth bits and empty the stack.

module postfix_truth_table_evaluator_unit
	import ptte_pkg::*;
#(
	parameter int MAX_VARS    = 6,
	parameter int STACK_DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [VAR_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic [VAR_W-1:0]     var_index,
	input  wire logic                 last_token,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [VEC_MAX_W-1:0]      truth_bits,
	output logic                      error
);

	localparam int VEC_W = 1 << MAX_VARS;

	logic [VAR_W-1:0]  var_count_q;
	ptte_stack_ctl_t   stack_ctl;
	logic [VEC_W-1:0]  top_d;
	logic [VEC_W-1:0]  cell_val [STACK_DEPTH];
	ptte_shift_t       cell_cmd [STACK_DEPTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q <= VAR_W'(1);
		end else if (cfg_valid) begin
			var_count_q <= cfg_data;
		end
	end

	ptte_ctrl #(
		.MAX_VARS    (MAX_VARS),
		.STACK_DEPTH (STACK_DEPTH),
		.VEC_W       (VEC_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.var_count  (var_count_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.var_index  (var_index),
		.last_token (last_token),
		.top_b      (cell_val[0]),
		.top_a      (cell_val[1]),
		.stack_ctl  (stack_ctl),
		.top_d      (top_d),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.truth_bits (truth_bits),
		.error      (error)
	);

	// cell 0 takes the new top on load_top; deeper cells follow the push or pop
	for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
		logic [VEC_W-1:0] up_val;
		logic [VEC_W-1:0] down_val;

		if (k == 0) begin : g_head
			assign up_val      = top_d;
			assign cell_cmd[k] = stack_ctl.load_top ? SHIFT_UP : SHIFT_HOLD;
		end else begin : g_body
			assign up_val      = cell_val[k-1];
			assign cell_cmd[k] = stack_ctl.push ? SHIFT_UP :
			                     stack_ctl.pop  ? SHIFT_DOWN : SHIFT_HOLD;
		end

		if (k == STACK_DEPTH - 1) begin : g_tail
			assign down_val = '0;
		end else begin : g_mid
			assign down_val = cell_val[k+1];
		end

		ptte_cell #(
			.W (VEC_W)
		) u_cell (
			.clk  (clk),
			.cmd  (cell_cmd[k]),
			.up   (up_val),
			.down (down_val),
			.val  (cell_val[k])
		);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ptte_cell.sv
// one entry of the shift-register stack: holds, takes the entry above or the one below
// depends on ptte_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptte_cell
	import ptte_pkg::*;
#(
	parameter int W = 64
) (
	input  wire logic        clk,
	input  wire ptte_shift_t cmd,
	input  wire logic [W-1:0] up,
	input  wire logic [W-1:0] down,
	output logic      [W-1:0] val
);

	logic [W-1:0] val_q;

	always_ff @(posedge clk) begin
		case (cmd)
			SHIFT_UP:   val_q <= up;
			SHIFT_DOWN: val_q <= down;
			default:    val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ptte_ctrl.sv
// token decode, depth and error tracking, new top value and the result register
// depends on ptte_pkg; drives the cell row of the top level
`timescale 1ns / 1ps
`default_nettype none

module ptte_ctrl
	import ptte_pkg::*;
#(
	parameter int MAX_VARS    = 6,
	parameter int STACK_DEPTH = 16,
	parameter int VEC_W       = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [VAR_W-1:0]     var_count,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic [VAR_W-1:0]     var_index,
	input  wire logic                 last_token,
	input  wire logic [VEC_W-1:0]     top_b,
	input  wire logic [VEC_W-1:0]     top_a,
	output ptte_stack_ctl_t           stack_ctl,
	output logic      [VEC_W-1:0]     top_d,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [VEC_MAX_W-1:0]      truth_bits,
	output logic                      error
);

	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [DW-1:0]        depth_q;
	logic                 err_seen_q;
	logic                 out_valid_q;
	logic [VEC_MAX_W-1:0] truth_q;
	logic                 error_q;

	logic                 accept;
	logic [VAR_W-1:0]     vc_eff;
	logic [VAR_W-1:0]     col_pos;
	logic [VEC_W-1:0]     mask;
	logic [VEC_W-1:0]     op_val;
	logic                 is_push;
	logic                 is_not;
	logic                 is_bin;
	logic                 bad;
	logic                 fail;
	logic [DW-1:0]        depth_next;
	logic                 err_next;
	logic [VEC_W-1:0]     top_next;
	logic                 res_err;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// register saturated into 1..MAX_VARS
	always_comb begin
		if (var_count == '0) begin
			vc_eff = VAR_W'(1);
		end else if (var_count > VAR_W'(MAX_VARS)) begin
			vc_eff = VAR_W'(MAX_VARS);
		end else begin
			vc_eff = var_count;
		end
	end

	assign col_pos = vc_eff - var_index;
	assign mask    = VEC_W'(ptte_row_mask(vc_eff));

	always_comb begin
		is_push = 1'b0;
		is_not  = 1'b0;
		is_bin  = 1'b0;
		bad     = 1'b0;
		op_val  = '0;
		unique case (mode)
			MODE_VAR: begin
				is_push = 1'b1;
				bad     = (var_index == '0) || (var_index > vc_eff);
				op_val  = VEC_W'(ptte_column(col_pos));
			end
			MODE_ONE: begin
				is_push = 1'b1;
				op_val  = '1;
			end
			MODE_ZERO: begin
				is_push = 1'b1;
				op_val  = '0;
			end
			MODE_NOT: begin
				is_not = 1'b1;
				op_val = ~top_b;
			end
			MODE_OR: begin
				is_bin = 1'b1;
				op_val = top_a | top_b;
			end
			MODE_AND: begin
				is_bin = 1'b1;
				op_val = top_a & top_b;
			end
			MODE_EQUIV: begin
				is_bin = 1'b1;
				op_val = ~(top_a ^ top_b);
			end
			MODE_IMPLIES: begin
				is_bin = 1'b1;
				op_val = ~top_a | top_b;
			end
			MODE_XOR: begin
				is_bin = 1'b1;
				op_val = top_a ^ top_b;
			end
			MODE_NOR: begin
				is_bin = 1'b1;
				op_val = ~(top_a | top_b);
			end
			MODE_NAND: begin
				is_bin = 1'b1;
				op_val = ~(top_a & top_b);
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	assign top_d = op_val & mask;

	// underflow, overflow, bad index or unknown token
	assign fail = bad
		|| (is_push && (depth_q == DW'(STACK_DEPTH)))
		|| (is_not && (depth_q == '0))
		|| (is_bin && (depth_q < DW'(2)));

	assign stack_ctl.push     = accept && !fail && is_push;
	assign stack_ctl.pop      = accept && !fail && is_bin;
	assign stack_ctl.load_top = accept && !fail && (is_push || is_not || is_bin);

	always_comb begin
		if (fail) begin
			depth_next = '0;
		end else if (is_push) begin
			depth_next = depth_q + DW'(1);
		end else if (is_bin) begin
			depth_next = depth_q - DW'(1);
		end else begin
			depth_next = depth_q;
		end
	end

	assign err_next = err_seen_q || fail;
	assign top_next = (is_push || is_not || is_bin) ? top_d : top_b;
	assign res_err  = err_next || (depth_next != DW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			err_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				depth_q    <= last_token ? '0 : depth_next;
				err_seen_q <= last_token ? 1'b0 : err_next;
			end
			if (accept && last_token) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat, masked with the row count in force now
	always_ff @(posedge clk) begin
		if (accept && last_token) begin
			truth_q <= res_err ? '0 : VEC_MAX_W'(top_next & mask);
			error_q <= res_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign truth_bits = truth_q;
	assign error      = error_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_postfix_truth_table_evaluator_unit.sv
// self-checking testbench for postfix_truth_table_evaluator_unit: directed token table, then
// random formulas over several var_count settings, scored against a stack model kept here
// depends on ptte_pkg and the evaluator RTL
`timescale 1ns / 1ps

module tb_postfix_truth_table_evaluator_unit;
	import ptte_pkg::*;

	localparam int STACK_ENTRIES = 16;
	localparam int VAR_LIMIT     = 6;
	localparam int NUM_PHASES    = 9;
	localparam int PHASE_ITEMS   = 92;
	localparam int CHOKE_CYCLES  = 60;
	localparam int STALL_LIMIT   = 1000;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 4'd15;

	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [VAR_W-1:0]  idx;
		logic              fin;
	} token_t;

	typedef struct packed {
		logic [VEC_MAX_W-1:0] bits;
		logic                 err;
	} table_res_t;

	typedef struct packed {
		logic [MODE_W-1:0]    op;
		logic [VAR_W-1:0]     idx;
		logic                 fin;
		logic                 typed;
		logic [VEC_MAX_W-1:0] want_bits;
		logic                 want_err;
	} plan_row_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [VAR_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [MODE_W-1:0]    mode       = '0;
	logic [VAR_W-1:0]     var_index  = '0;
	logic                 last_token = 1'b0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [VEC_MAX_W-1:0] truth_bits;
	logic                 error;

	// shadow of the block's stack and register
	logic [VEC_MAX_W-1:0] shadow_stack [STACK_ENTRIES];
	int unsigned          shadow_fill = 0;
	bit                   shadow_err  = 1'b0;
	logic [VAR_W-1:0]     shadow_vars = 3'd1;

	table_res_t  awaited_tables [$];
	token_t      batch [$];
	int unsigned items_sent     = 0;
	int unsigned mismatch_count = 0;
	int unsigned stall_cycles   = 0;
	int unsigned choke_requests = 0;
	bit          calm           = 1'b0;
	bit          eager          = 1'b0;

	logic [VAR_W-1:0] phase_vars [0:NUM_PHASES-1] =
		'{3'd0, 3'd6, 3'd3, 3'd7, 3'd2, 3'd1, 3'd5, 3'd4, 3'd6};

	// opening table, run with var_count at its reset value of one (two rows)
	plan_row_t opening_plan [0:25] = '{
		'{MODE_ONE,     3'd0, 1'b1, 1'b1, 64'h3, 1'b0},
		'{MODE_VAR,     3'd1, 1'b1, 1'b1, 64'h2, 1'b0},
		'{MODE_NOT,     3'd0, 1'b1, 1'b1, 64'h0, 1'b1}, // nothing to invert
		'{MODE_VAR,     3'd0, 1'b1, 1'b1, 64'h0, 1'b1}, // index zero
		'{MODE_VAR,     3'd7, 1'b1, 1'b1, 64'h0, 1'b1}, // index past var_count
		'{MODE_UNUSED,  3'd0, 1'b1, 1'b1, 64'h0, 1'b1},
		'{MODE_ONE,     3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_OR,      3'd0, 1'b1, 1'b1, 64'h0, 1'b1}, // one operand only
		'{MODE_ONE,     3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_ZERO,    3'd0, 1'b1, 1'b1, 64'h0, 1'b1}, // two entries left
		'{MODE_VAR,     3'd1, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_NOT,     3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_ONE,     3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_OR,      3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_VAR,     3'd1, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_AND,     3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_ZERO,    3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_EQUIV,   3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_VAR,     3'd1, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_IMPLIES, 3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_ONE,     3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_XOR,     3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_VAR,     3'd1, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_NOR,     3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_ZERO,    3'd0, 1'b0, 1'b0, 64'h0, 1'b0},
		'{MODE_NAND,    3'd0, 1'b1, 1'b0, 64'h0, 1'b0}
	};

	postfix_truth_table_evaluator_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.var_index  (var_index),
		.last_token (last_token),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.truth_bits (truth_bits),
		.error      (error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int live_vars();
		int v;
		v = int'(shadow_vars);
		if (v < 1) v = 1;
		if (v > VAR_LIMIT) v = VAR_LIMIT;
		return v;
	endfunction

	function automatic logic [VEC_MAX_W-1:0] live_mask();
		int v;
		v = live_vars();
		if (v >= 6) return '1;
		return (64'd1 << (1 << v)) - 64'd1;
	endfunction

	function automatic void flag_stack_error();
		shadow_err  = 1'b1;
		shadow_fill = 0;
	endfunction

	function automatic void push_vector(input logic [VEC_MAX_W-1:0] v);
		if (shadow_fill >= STACK_ENTRIES) begin
			flag_stack_error();
		end else begin
			shadow_stack[shadow_fill] = v & live_mask();
			shadow_fill++;
		end
	endfunction

	// add one token to the end of the batch
	function automatic void append_token(input token_t t);
		batch.insert(batch.size(), t);
	endfunction

	// advance the shadow stack by one token; a final token yields the table
	task automatic eval_postfix_token(input token_t t, output bit emits, output table_res_t res);
		int                   vc;
		logic [VEC_MAX_W-1:0] a;
		logic [VEC_MAX_W-1:0] b;
		logic [VEC_MAX_W-1:0] r;
		logic [VEC_MAX_W-1:0] col;
		vc    = live_vars();
		emits = 1'b0;
		res   = '0;
		case (t.op)
			MODE_VAR: begin
				if (t.idx == '0 || int'(t.idx) > vc) begin
					flag_stack_error();
				end else begin
					col = '0;
					for (int i = 0; i < VEC_MAX_W; i++) begin
						col[i] = ((i >> (vc - int'(t.idx))) & 1) != 0;
					end
					push_vector(col);
				end
			end
			MODE_ONE:  push_vector('1);
			MODE_ZERO: push_vector('0);
			MODE_NOT: begin
				if (shadow_fill < 1) begin
					flag_stack_error();
				end else begin
					shadow_stack[shadow_fill-1] = ~shadow_stack[shadow_fill-1] & live_mask();
				end
			end
			MODE_OR, MODE_AND, MODE_EQUIV, MODE_IMPLIES, MODE_XOR, MODE_NOR, MODE_NAND: begin
				if (shadow_fill < 2) begin
					flag_stack_error();
				end else begin
					// a is the older entry, b the newer
					b = shadow_stack[shadow_fill-1];
					a = shadow_stack[shadow_fill-2];
					case (t.op)
						MODE_OR:      r = a | b;
						MODE_AND:     r = a & b;
						MODE_EQUIV:   r = ~(a ^ b);
						MODE_IMPLIES: r = ~a | b;
						MODE_XOR:     r = a ^ b;
						MODE_NOR:     r = ~(a | b);
						default:      r = ~(a & b);
					endcase
					shadow_fill--;
					shadow_stack[shadow_fill-1] = r & live_mask();
				end
			end
			default: flag_stack_error();
		endcase
		if (t.fin) begin
			emits = 1'b1;
			if (shadow_err || shadow_fill != 1) begin
				res = '{'0, 1'b1};
			end else begin
				res = '{shadow_stack[0] & live_mask(), 1'b0};
			end
			shadow_fill = 0;
			shadow_err  = 1'b0;
		end
	endtask

	function automatic token_t push_token(input int vc);
		token_t t;
		int     r;
		r     = $urandom_range(0, 4);
		t.fin = 1'b0;
		t.idx = VAR_W'($urandom_range(0, 7));
		if (r < 3) begin
			t.op  = MODE_VAR;
			t.idx = VAR_W'($urandom_range(1, vc));
		end else if (r == 3) begin
			t.op = MODE_ONE;
		end else begin
			t.op = MODE_ZERO;
		end
		return t;
	endfunction

	function automatic token_t binary_token();
		token_t t;
		t.op  = MODE_W'($urandom_range(int'(MODE_OR), int'(MODE_NAND)));
		t.idx = VAR_W'($urandom_range(0, 7));
		t.fin = 1'b0;
		return t;
	endfunction

	// one formula into batch: mostly well formed, some corrupted, some pure noise
	function automatic void build_sequence();
		int     pick;
		int     vc;
		int     cap;
		int     depth;
		int     budget;
		int     n;
		int     k;
		int     r;
		token_t t;
		batch.delete();
		vc   = live_vars();
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++) begin
				t.op  = MODE_W'($urandom_range(0, 15));
				t.idx = VAR_W'($urandom_range(0, 7));
				t.fin = (k == n - 1) || ($urandom_range(0, 3) == 0);
				append_token(t);
			end
		end else begin
			depth = 0;
			if (pick >= 90) begin
				// fill the stack to the brim, one short of it or one past it
				cap = $urandom_range(STACK_ENTRIES - 1, STACK_ENTRIES + 1);
				repeat (cap) begin
					append_token(push_token(vc));
					depth++;
				end
			end else begin
				cap = $urandom_range(1, 5);
			end
			budget = $urandom_range(0, 3 * cap);
			while (budget > 0) begin
				budget--;
				r = $urandom_range(0, 2);
				if (depth == 0 || (r == 0 && depth < cap)) begin
					append_token(push_token(vc));
					depth++;
				end else if (r == 1 || depth < 2) begin
					t.op  = MODE_NOT;
					t.idx = VAR_W'($urandom_range(0, 7));
					t.fin = 1'b0;
					append_token(t);
				end else begin
					append_token(binary_token());
					depth--;
				end
			end
			if (depth == 0) begin
				append_token(push_token(vc));
				depth++;
			end
			while (depth > 1) begin
				append_token(binary_token());
				depth--;
			end
			t     = batch.pop_back();
			t.fin = 1'b1;
			append_token(t);
			if (pick < 30) begin
				k          = $urandom_range(0, batch.size() - 1);
				t          = batch[k];
				t.op       = MODE_W'($urandom_range(0, 15));
				t.idx      = VAR_W'($urandom_range(0, 7));
				batch[k]   = t;
			end
		end
	endfunction

	task automatic put_token(input token_t t, input bit typed, input table_res_t typed_res);
		bit         emits;
		table_res_t res;
		if (!calm && !eager && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= t.op;
		var_index  <= t.idx;
		last_token <= t.fin;
		do @(posedge clk); while (!in_ready);
		eval_postfix_token(t, emits, res);
		if (emits) awaited_tables.insert(awaited_tables.size(), typed ? typed_res : res);
		items_sent++;
	endtask

	task automatic send_batch();
		foreach (batch[k]) put_token(batch[k], 1'b0, '0);
	endtask

	task automatic drain_tables();
		in_valid <= 1'b0;
		while (awaited_tables.size() != 0) @(posedge clk);
	endtask

	task automatic write_var_count(input logic [VAR_W-1:0] v);
		drain_tables();
		// tokens without a table may still be in flight
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		shadow_vars = v;
		cfg_valid  <= 1'b0;
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic squeeze_output();
		eager = 1'b1;
		choke_requests <= choke_requests + 1;
		repeat (14) begin
			build_sequence();
			send_batch();
		end
		eager = 1'b0;
	endtask

	initial begin : stimulus
		token_t     tok;
		table_res_t want;
		int         phase_start;
		bit         paused;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_plan[r]) begin
			tok  = '{opening_plan[r].op, opening_plan[r].idx, opening_plan[r].fin};
			want = '{opening_plan[r].want_bits, opening_plan[r].want_err};
			put_token(tok, opening_plan[r].typed, want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_var_count(phase_vars[p]);
			if (p == NUM_PHASES - 1) calm = 1'b1;
			phase_start = items_sent;
			if (p == 2) squeeze_output();
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if (p == 5 && !paused && items_sent - phase_start > PHASE_ITEMS / 2) begin
					drain_tables();
					@(posedge clk);
					paused = 1'b1;
				end
				build_sequence();
				send_batch();
			end
		end

		drain_tables();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS postfix_truth_table_evaluator_unit");
		end else begin
			$display("FAIL postfix_truth_table_evaluator_unit");
		end
		$finish;
	end

	initial begin : receiver
		int unsigned choke_served;
		choke_served = 0;
		forever begin
			@(posedge clk);
			if (choke_served != choke_requests) begin
				choke_served++;
				out_ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		table_res_t head;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_tables.size() == 0) begin
				$display("%0t: result beat with none expected, truth_bits=%h error=%b",
					$time, truth_bits, error);
				mismatch_count++;
			end else begin
				head = awaited_tables.pop_front();
				if (truth_bits !== head.bits) begin
					$display("%0t: truth_bits expected %h actual %h", $time, head.bits, truth_bits);
					mismatch_count++;
				end
				if (error !== head.err) begin
					$display("%0t: error expected %b actual %b", $time, head.err, error);
					mismatch_count++;
				end
			end
		end
	end

	// stall count resets on any beat on any channel
	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
		$display("FAIL postfix_truth_table_evaluator_unit");
		$finish;
	end

endmodule

FILE: postfix_truth_table_evaluator_unit.f
hw/rtl/ptte_pkg.sv
hw/rtl/ptte_cell.sv
hw/rtl/ptte_ctrl.sv
hw/rtl/postfix_truth_table_evaluator_unit.sv
tb/sv/tb_postfix_truth_table_evaluator_unit.sv
